// ===== rtl/skst_pkg.sv =====
// shared types, constants and name helpers for the sorted keyed score table
package skst_pkg;

  // default geometry
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_CHARS   = 10;
  localparam int NAME_CHARS  = 10;
  localparam int NAME_BITS   = 8 * NAME_CHARS;

  // item kinds, the unused code decodes as a read
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_BADPOS    = 3'd5,
    ST_REMOVED   = 3'd6,
    ST_READ      = 3'd7
  } status_e;

  // one stored table entry
  typedef struct packed {
    logic        [63:0] head;
    logic        [15:0] tail;
    logic signed [31:0] score;
  } entry_t;

  // one result item
  typedef struct packed {
    status_e            status;
    logic        [63:0] head;
    logic        [15:0] tail;
    logic signed [31:0] score;
    logic        [5:0]  position;
    logic        [6:0]  total;
  } res_t;

  // zero everything from the first zero character on and past key_chars
  function automatic logic [NAME_BITS-1:0] clean_name(logic [NAME_BITS-1:0] name,
                                                      int key_chars);
    logic [NAME_BITS-1:0] res;
    logic                 ended;
    logic [7:0]           ch;
    res   = '0;
    ended = 1'b0;
    for (int c = 0; c < NAME_CHARS; c++) begin
      ch = name[NAME_BITS-1-8*c -: 8];
      if (ch == 8'd0 || c >= key_chars) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[NAME_BITS-1-8*c -: 8] = ch;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/skst_mem.sv =====
// entry memory: one write port, one registered read port
module skst_mem #(
  parameter  int DEPTH = skst_pkg::TABLE_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output skst_pkg::entry_t rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  skst_pkg::entry_t wr_data_i
);

  skst_pkg::entry_t mem_q [DEPTH];
  skst_pkg::entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/skst_seq.sv =====
// sequencer: scans, shifts and updates table entries through the entry memory
module skst_seq #(
  parameter  int TABLE_DEPTH = skst_pkg::TABLE_DEPTH,
  parameter  int KEY_CHARS   = skst_pkg::KEY_CHARS,
  localparam int IW          = $clog2(TABLE_DEPTH),
  localparam int CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [63:0]        name_head_i,
  input  logic [15:0]        name_tail_i,
  input  logic signed [31:0] new_score_i,
  input  logic [5:0]         position_i,
  output logic               rd_en_o,
  output logic [IW-1:0]      rd_addr_o,
  input  skst_pkg::entry_t   rd_data_i,
  output logic               wr_en_o,
  output logic [IW-1:0]      wr_addr_o,
  output skst_pkg::entry_t   wr_data_o,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output skst_pkg::res_t     res_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SCAN     = 7'b0000010,
    ST_SHIFT_DN = 7'b0000100,
    ST_FETCH    = 7'b0001000,
    ST_GRAB     = 7'b0010000,
    ST_SHIFT_UP = 7'b0100000,
    ST_RESULT   = 7'b1000000
  } state_e;

  state_e                            state_q, state_d;
  logic   [CW-1:0]                   cnt_q, cnt_d;
  logic                              rvalid_q, rvalid_d;
  logic   [IW-1:0]                   ridx_q, ridx_d;
  logic   [CW-1:0]                   nxt_q, nxt_d;
  logic   [CW-1:0]                   at_q, at_d;
  logic   [1:0]                      kind_q, kind_d;
  logic   [skst_pkg::NAME_BITS-1:0]  key_q, key_d;
  logic signed [31:0]                score_q, score_d;
  logic   [IW-1:0]                   pos_q, pos_d;
  skst_pkg::res_t                    res_q, res_d;

  logic   [skst_pkg::NAME_BITS-1:0]  clean;
  logic                              pos_ok;
  logic   [skst_pkg::NAME_BITS-1:0]  stored_key;
  logic                              key_lt;
  logic                              key_eq;
  skst_pkg::entry_t                  new_entry;

  assign clean      = skst_pkg::clean_name({name_head_i, name_tail_i}, KEY_CHARS);
  assign pos_ok     = {26'd0, position_i} < 32'(cnt_q);
  assign stored_key = {rd_data_i.head, rd_data_i.tail};
  assign key_lt     = stored_key < key_q;
  assign key_eq     = stored_key == key_q;
  assign new_entry  = '{head: key_q[79:16], tail: key_q[15:0], score: score_q};

  // next state and memory access
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    nxt_d     = nxt_q;
    at_d      = at_q;
    kind_d    = kind_q;
    key_d     = key_q;
    score_d   = score_q;
    pos_d     = pos_q;
    res_d     = res_q;
    rd_en_o   = 1'b0;
    rd_addr_o = nxt_q[IW-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = ridx_q;
    wr_data_o = rd_data_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d           = kind_i;
          key_d            = clean;
          score_d          = new_score_i;
          pos_d            = IW'(position_i);
          res_d            = '0;
          res_d.total      = 7'(cnt_q);
          if (kind_i == skst_pkg::KIND_ADD) begin
            if (clean[79:72] == 8'd0) begin
              res_d.status = skst_pkg::ST_EMPTY;
              state_d      = ST_RESULT;
            end else begin
              nxt_d        = '0;
              state_d      = ST_SCAN;
            end
          end else if (!pos_ok) begin
            res_d.status   = skst_pkg::ST_BADPOS;
            state_d        = ST_RESULT;
          end else begin
            state_d        = ST_FETCH;
          end
        end
      end

      // walk entries until the first key not below the new name
      ST_SCAN: begin
        if (rvalid_q && key_eq) begin
          res_d.head     = key_q[79:16];
          res_d.tail     = key_q[15:0];
          res_d.score    = score_q;
          res_d.position = 6'(ridx_q);
          if (rd_data_i.score != score_q) begin
            wr_en_o      = 1'b1;
            wr_addr_o    = ridx_q;
            wr_data_o    = new_entry;
            res_d.status = skst_pkg::ST_UPDATED;
          end else begin
            res_d.status = skst_pkg::ST_UNCHANGED;
          end
          state_d        = ST_RESULT;
        end else if ((rvalid_q && !key_lt) || (!rvalid_q && nxt_q == cnt_q)) begin
          at_d = rvalid_q ? CW'(ridx_q) : cnt_q;
          if (cnt_q == CW'(TABLE_DEPTH)) begin
            res_d.status = skst_pkg::ST_FULL;
            state_d      = ST_RESULT;
          end else begin
            nxt_d        = cnt_q;
            state_d      = ST_SHIFT_DN;
          end
        end else if (nxt_q < cnt_q) begin
          rd_en_o = 1'b1;
          nxt_d   = nxt_q + 1'b1;
        end
      end

      // move entries one place down from the end, then place the new one
      ST_SHIFT_DN: begin
        if (rvalid_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = ridx_q + 1'b1;
          wr_data_o = rd_data_i;
        end
        if (nxt_q > at_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = IW'(nxt_q - 1'b1);
          nxt_d     = nxt_q - 1'b1;
        end else if (!rvalid_q) begin
          wr_en_o        = 1'b1;
          wr_addr_o      = at_q[IW-1:0];
          wr_data_o      = new_entry;
          cnt_d          = cnt_q + 1'b1;
          res_d.status   = skst_pkg::ST_INSERTED;
          res_d.head     = key_q[79:16];
          res_d.tail     = key_q[15:0];
          res_d.score    = score_q;
          res_d.position = 6'(at_q);
          res_d.total    = 7'(cnt_q + 1'b1);
          state_d        = ST_RESULT;
        end
      end

      ST_FETCH: begin
        rd_en_o   = 1'b1;
        rd_addr_o = pos_q;
        state_d   = ST_GRAB;
      end

      // entry at the position is on the read port
      ST_GRAB: begin
        res_d.head     = rd_data_i.head;
        res_d.tail     = rd_data_i.tail;
        res_d.score    = rd_data_i.score;
        res_d.position = 6'(pos_q);
        if (kind_q == skst_pkg::KIND_REMOVE) begin
          nxt_d        = CW'(pos_q) + 1'b1;
          state_d      = ST_SHIFT_UP;
        end else begin
          res_d.status = skst_pkg::ST_READ;
          state_d      = ST_RESULT;
        end
      end

      // move later entries one place up to close the gap
      ST_SHIFT_UP: begin
        if (rvalid_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = ridx_q - 1'b1;
          wr_data_o = rd_data_i;
        end
        if (nxt_q < cnt_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = nxt_q[IW-1:0];
          nxt_d     = nxt_q + 1'b1;
        end else if (!rvalid_q) begin
          cnt_d        = cnt_q - 1'b1;
          res_d.status = skst_pkg::ST_REMOVED;
          res_d.total  = 7'(cnt_q - 1'b1);
          state_d      = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    rvalid_d = rd_en_o;
    ridx_d   = rd_addr_o;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rvalid_d;
    end
  end

  // item and working registers
  always_ff @(posedge clk_i) begin
    ridx_q  <= ridx_d;
    nxt_q   <= nxt_d;
    at_q    <= at_d;
    kind_q  <= kind_d;
    key_q   <= key_d;
    score_q <= score_d;
    pos_q   <= pos_d;
    res_q   <= res_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign res_valid_o = state_q == ST_RESULT;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // entry count never exceeds the table depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // a shift never reads the entry it writes in the same cycle
  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_o && wr_en_o) |-> (rd_addr_o != wr_addr_o))
    else $error("read and write to the same entry");

  // count moves only at the end of an insert or a remove
  a_cnt_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> ($past(state_q) == ST_SHIFT_DN || $past(state_q) == ST_SHIFT_UP))
    else $error("entry count changed outside a shift");

  // no read left in flight once back to idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !rvalid_q)
    else $error("read in flight while idle");
`endif

endmodule

// ===== rtl/sorted_keyed_score_table_unit.sv =====
// Add scans one entry per cycle up to the first key not below the name, then shifts one
// entry per cycle and places the new one; an update stops at its match.
// Remove moves the later entries one place up, and a read fetches the entry at its position.
// One item is in the sequencer at a time; the single read port of the entry memory sets
// the rate. Results leave through an output register once it is empty or its transfer completes.
// Reset clears the entry count and the control state; the entry memory is not cleared.
module sorted_keyed_score_table_unit #(
  parameter int TABLE_DEPTH = skst_pkg::TABLE_DEPTH,
  parameter int KEY_CHARS   = skst_pkg::KEY_CHARS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [63:0]        name_head_i,
  input  logic [15:0]        name_tail_i,
  input  logic signed [31:0] new_score_i,
  input  logic [5:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [63:0]        out_name_head_o,
  output logic [15:0]        out_name_tail_o,
  output logic signed [31:0] out_score_o,
  output logic [5:0]         out_position_o,
  output logic [6:0]         entry_total_o
);

  localparam int IW = $clog2(TABLE_DEPTH);

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  skst_pkg::entry_t rd_data;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  skst_pkg::entry_t wr_data;
  logic             res_valid;
  logic             res_take;
  skst_pkg::res_t   res;
  logic             out_valid_q;
  skst_pkg::res_t   out_q;

  skst_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_CHARS   (KEY_CHARS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .name_head_i (name_head_i),
    .name_tail_i (name_tail_i),
    .new_score_i (new_score_i),
    .position_i  (position_i),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  skst_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // output register takes a result when empty or when its transfer completes
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign out_name_head_o = out_q.head;
  assign out_name_tail_o = out_q.tail;
  assign out_score_o     = out_q.score;
  assign out_position_o  = out_q.position;
  assign entry_total_o   = out_q.total;

endmodule
